>>> src/scfd_pkg.sv
// Shared constants, types and helpers for the SCF density and Fock step block.
`default_nettype none
package scfd_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int BASIS_MAX_DEF = 8;
  localparam int ACC_W         = 64;
  localparam int OPB_W         = VALUE_BITS + 2;
  localparam int PROD_W        = VALUE_BITS + OPB_W;
  localparam int SH_DENS       = 15;
  localparam int SH_FOCK       = 17;

  localparam logic [1:0] CMD_LOAD_C = 2'd0;
  localparam logic [1:0] CMD_LOAD_H = 2'd1;
  localparam logic [1:0] CMD_LOAD_I = 2'd2;
  localparam logic [1:0] CMD_RUN    = 2'd3;

  localparam logic [1:0] REG_BASIS    = 2'd0;
  localparam logic [1:0] REG_OCCUPIED = 2'd1;

  localparam logic KIND_FOCK   = 1'b0;
  localparam logic KIND_ENERGY = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_D_LOAD, S_D_INIT, S_D_RD, S_D_MUL, S_D_ACC, S_D_WR,
    S_F_LOAD, S_F_INIT, S_F_RD, S_F_MUL, S_F_ACC, S_F_OUT,
    S_E_RD, S_E_MUL, S_E_ACC, S_E_OUT
  } state_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] val;
    logic                         clip;
  } sat_t;

  // Clip a wide accumulator to the signed value range.
  function automatic sat_t sat_val(input logic signed [ACC_W-1:0] x);
    sat_t res;
    res.val  = x[VALUE_BITS-1:0];
    res.clip = 1'b0;
    if (x[ACC_W-1:VALUE_BITS-1] != {(ACC_W-VALUE_BITS+1){x[ACC_W-1]}}) begin
      res.clip = 1'b1;
      res.val  = x[ACC_W-1] ? {1'b1, {(VALUE_BITS-1){1'b0}}} :
                              {1'b0, {(VALUE_BITS-1){1'b1}}};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> src/scf_density_fock_energy_step.sv
// Top level: one restricted SCF step with damped density, Fock build and energy.
//
// Usage: load items (cmd 0..2) write the coefficient, core Hamiltonian and
// two-electron integral memories and are taken one per cycle while the block
// is idle; they give no output word. A run item (cmd 3) forms the damped
// density, then the lower triangle of the Fock matrix row by row, then one
// energy word with last set. Configuration (basis_count, occupied_count) is
// written through the cfg port, which is always ready.
// One shared multiplier and accumulator do all the arithmetic; each product
// term passes through a read, a multiply and an accumulate state. in_stall
// is high for the whole run, and the first Fock word follows only once every
// density element has been written.
// Reset clears the density (through per-entry valid bits), the state machine
// and the output valid flag; it sets basis_count to 8 and occupied_count to 1.
// When out_stall is high the pending word holds and the sequencer waits
// before issuing the next word.
`default_nettype none
module scf_density_fock_energy_step #(
  parameter int BASIS_MAX = scfd_pkg::BASIS_MAX_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_cmd,
  input  wire logic [2:0]                         in_index_a,
  input  wire logic [2:0]                         in_index_b,
  input  wire logic [2:0]                         in_index_c,
  input  wire logic [2:0]                         in_index_d,
  input  wire logic signed [scfd_pkg::VALUE_BITS-1:0] in_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_kind,
  output logic [2:0]                              out_row,
  output logic [2:0]                              out_col,
  output logic signed [scfd_pkg::VALUE_BITS-1:0]  out_result_value,
  output logic                                    out_saturated,
  output logic                                    out_last,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [1:0]                         cfg_index,
  input  wire logic [3:0]                         cfg_data
);
  import scfd_pkg::*;

  localparam int B2  = BASIS_MAX * BASIS_MAX;
  localparam int B4  = B2 * B2;
  localparam int IW  = (BASIS_MAX > 1) ? $clog2(BASIS_MAX) : 1;
  localparam int A2W = (B2 > 1) ? $clog2(B2) : 1;
  localparam int A4W = (B4 > 1) ? $clog2(B4) : 1;
  localparam int CW  = $clog2(BASIS_MAX + 1);

  function automatic logic [A2W-1:0] addr2(input logic [IW-1:0] x, input logic [IW-1:0] y);
    return A2W'(int'(x) * BASIS_MAX + int'(y));
  endfunction

  function automatic logic [A2W-1:0] sym2(input logic [IW-1:0] x, input logic [IW-1:0] y);
    return (x >= y) ? addr2(x, y) : addr2(y, x);
  endfunction

  function automatic logic [A4W-1:0] addr4(input logic [IW-1:0] w, input logic [IW-1:0] x,
                                           input logic [IW-1:0] y, input logic [IW-1:0] z);
    return A4W'(((int'(w) * BASIS_MAX + int'(x)) * BASIS_MAX + int'(y)) * BASIS_MAX
                + int'(z));
  endfunction

  // Storage.
  logic [VALUE_BITS-1:0] coef_mem [B2];
  logic [VALUE_BITS-1:0] ham_mem  [B2];
  logic [VALUE_BITS-1:0] int_mem  [B4];
  logic [VALUE_BITS-1:0] den_mem  [B2];
  logic [VALUE_BITS-1:0] fock_mem [B2];
  logic [B2-1:0]         den_vld_r;

  state_t state_r, state_nxt;
  logic [3:0]    basis_r, occ_r;
  logic [CW-1:0] n_r, n_nxt, m_r, m_nxt, n_clamp, m_clamp;
  logic [IW-1:0] ca_r, ca_nxt, cb_r, cb_nxt, cc_r, cc_nxt, cd_r, cd_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [VALUE_BITS-1:0] opa;
  logic signed [OPB_W-1:0]      opb;

  logic [A2W-1:0] coef_ra0, coef_ra1, ham_ra, den_ra, fock_ra;
  logic [A4W-1:0] int_ra0, int_ra1;
  logic signed [VALUE_BITS-1:0] coef_rd0_r, coef_rd1_r, ham_rd_r, den_rd_r, fock_rd_r;
  logic signed [VALUE_BITS-1:0] int_rd0_r, int_rd1_r;
  logic den_rdv_r;
  logic signed [VALUE_BITS-1:0] den_op;

  logic in_acc, out_free, out_ld, den_we, fock_we;
  logic last_a, last_b, last_c, last_d, last_m;
  sat_t sat_res, den_sat;
  logic signed [ACC_W-1:0] den_half;

  logic                         out_valid_r, out_kind_r, out_sat_r, out_last_r;
  logic [2:0]                   out_row_r, out_col_r;
  logic signed [VALUE_BITS-1:0] out_val_r;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign n_clamp  = (int'(basis_r) > BASIS_MAX) ? CW'(BASIS_MAX) : CW'(basis_r);
  assign m_clamp  = (int'(occ_r) > BASIS_MAX) ? CW'(BASIS_MAX) : CW'(occ_r);
  assign last_a   = (CW'(ca_r) == n_r - 1'b1);
  assign last_b   = (CW'(cb_r) == n_r - 1'b1);
  assign last_c   = (CW'(cc_r) == n_r - 1'b1);
  assign last_d   = (CW'(cd_r) == n_r - 1'b1);
  assign last_m   = (CW'(cc_r) == m_r - 1'b1);
  assign sat_res  = sat_val(acc_r);
  assign den_half = acc_r >>> 1;
  assign den_sat  = sat_val(den_half);
  assign den_op   = den_rdv_r ? den_rd_r : '0;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_cmd == CMD_RUN) begin
          state_nxt = (n_clamp == '0) ? S_E_OUT : S_D_LOAD;
        end
      end
      S_D_LOAD: state_nxt = S_D_INIT;
      S_D_INIT: state_nxt = (m_r == '0) ? S_D_WR : S_D_RD;
      S_D_RD:   state_nxt = S_D_MUL;
      S_D_MUL:  state_nxt = S_D_ACC;
      S_D_ACC:  state_nxt = last_m ? S_D_WR : S_D_RD;
      S_D_WR:   state_nxt = (cb_r == ca_r && last_a) ? S_F_LOAD : S_D_LOAD;
      S_F_LOAD: state_nxt = S_F_INIT;
      S_F_INIT: state_nxt = S_F_RD;
      S_F_RD:   state_nxt = S_F_MUL;
      S_F_MUL:  state_nxt = S_F_ACC;
      S_F_ACC:  state_nxt = (last_c && last_d) ? S_F_OUT : S_F_RD;
      S_F_OUT: begin
        if (out_free) begin
          state_nxt = (cb_r == ca_r && last_a) ? S_E_RD : S_F_LOAD;
        end
      end
      S_E_RD:   state_nxt = S_E_MUL;
      S_E_MUL:  state_nxt = S_E_ACC;
      S_E_ACC:  state_nxt = (last_a && last_b) ? S_E_OUT : S_E_RD;
      S_E_OUT:  state_nxt = out_free ? S_IDLE : S_E_OUT;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Counters, accumulator, memory addresses and handshake outputs.
  always_comb begin
    ca_nxt   = ca_r;
    cb_nxt   = cb_r;
    cc_nxt   = cc_r;
    cd_nxt   = cd_r;
    acc_nxt  = acc_r;
    n_nxt    = n_r;
    m_nxt    = m_r;
    out_ld   = 1'b0;
    den_we   = 1'b0;
    fock_we  = 1'b0;
    in_stall = (state_r != S_IDLE);
    coef_ra0 = addr2(ca_r, cc_r);
    coef_ra1 = addr2(cb_r, cc_r);
    int_ra0  = addr4(ca_r, cc_r, cb_r, cd_r);
    int_ra1  = addr4(ca_r, cc_r, cd_r, cb_r);
    ham_ra   = addr2(ca_r, cb_r);
    den_ra   = sym2(ca_r, cb_r);
    fock_ra  = sym2(ca_r, cb_r);
    opa      = coef_rd0_r;
    opb      = OPB_W'(coef_rd1_r);
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_cmd == CMD_RUN) begin
          n_nxt   = n_clamp;
          m_nxt   = m_clamp;
          ca_nxt  = '0;
          cb_nxt  = '0;
          acc_nxt = '0;
        end
      end
      S_D_INIT: begin
        acc_nxt = ACC_W'(den_op);
        cc_nxt  = '0;
      end
      S_D_ACC: begin
        acc_nxt = acc_r + ACC_W'(prod_r >>> SH_DENS);
        cc_nxt  = cc_r + 1'b1;
      end
      S_D_WR: begin
        den_we = 1'b1;
        if (cb_r == ca_r) begin
          cb_nxt = '0;
          ca_nxt = last_a ? '0 : ca_r + 1'b1;
        end else begin
          cb_nxt = cb_r + 1'b1;
        end
      end
      S_F_INIT: begin
        acc_nxt = ACC_W'(ham_rd_r);
        cc_nxt  = '0;
        cd_nxt  = '0;
      end
      S_F_RD: begin
        den_ra = sym2(cd_r, cc_r);
      end
      S_F_MUL: begin
        opa = den_op;
        opb = (OPB_W'(int_rd0_r) <<< 1) - OPB_W'(int_rd1_r);
      end
      S_F_ACC: begin
        acc_nxt = acc_r + ACC_W'(prod_r >>> SH_FOCK);
        if (last_d) begin
          cd_nxt = '0;
          cc_nxt = cc_r + 1'b1;
        end else begin
          cd_nxt = cd_r + 1'b1;
        end
      end
      S_F_OUT: begin
        if (out_free) begin
          out_ld  = 1'b1;
          fock_we = 1'b1;
          if (cb_r == ca_r) begin
            cb_nxt = '0;
            ca_nxt = last_a ? '0 : ca_r + 1'b1;
            if (last_a) begin
              acc_nxt = '0;
            end
          end else begin
            cb_nxt = cb_r + 1'b1;
          end
        end
      end
      S_E_RD: begin
        den_ra = sym2(cb_r, ca_r);
        ham_ra = addr2(cb_r, ca_r);
      end
      S_E_MUL: begin
        opa = den_op;
        opb = OPB_W'(ham_rd_r) + OPB_W'(fock_rd_r);
      end
      S_E_ACC: begin
        acc_nxt = acc_r + ACC_W'(prod_r >>> SH_FOCK);
        if (last_b) begin
          cb_nxt = '0;
          ca_nxt = ca_r + 1'b1;
        end else begin
          cb_nxt = cb_r + 1'b1;
        end
      end
      S_E_OUT: begin
        out_ld = out_free;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      basis_r     <= 4'd8;
      occ_r       <= 4'd1;
      den_vld_r   <= '0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      m_r         <= '0;
      ca_r        <= '0;
      cb_r        <= '0;
      cc_r        <= '0;
      cd_r        <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      m_r     <= m_nxt;
      ca_r    <= ca_nxt;
      cb_r    <= cb_nxt;
      cc_r    <= cc_nxt;
      cd_r    <= cd_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BASIS) begin
          basis_r <= cfg_data;
        end else if (cfg_index == REG_OCCUPIED) begin
          occ_r <= cfg_data;
        end
      end
      if (den_we) begin
        den_vld_r[sym2(ca_r, cb_r)] <= 1'b1;
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath and output payload.
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    prod_r <= opa * opb;
    if (out_ld) begin
      out_kind_r <= (state_r == S_E_OUT) ? KIND_ENERGY : KIND_FOCK;
      out_last_r <= (state_r == S_E_OUT);
      out_row_r  <= (state_r == S_E_OUT) ? 3'd0 : 3'(ca_r);
      out_col_r  <= (state_r == S_E_OUT) ? 3'd0 : 3'(cb_r);
      out_val_r  <= sat_res.val;
      out_sat_r  <= sat_res.clip;
    end
  end

  // Memories: loads write while idle, the sequencer reads every cycle.
  always_ff @(posedge clk) begin
    if (in_acc && in_cmd != CMD_RUN && int'(in_index_a) < BASIS_MAX &&
        int'(in_index_b) < BASIS_MAX) begin
      if (in_cmd == CMD_LOAD_C) begin
        coef_mem[addr2(IW'(in_index_a), IW'(in_index_b))] <= in_value;
      end else if (in_cmd == CMD_LOAD_H) begin
        ham_mem[addr2(IW'(in_index_a), IW'(in_index_b))] <= in_value;
      end else if (int'(in_index_c) < BASIS_MAX && int'(in_index_d) < BASIS_MAX) begin
        int_mem[addr4(IW'(in_index_a), IW'(in_index_b), IW'(in_index_c),
                      IW'(in_index_d))] <= in_value;
      end
    end
    if (den_we) begin
      den_mem[sym2(ca_r, cb_r)] <= den_sat.val;
    end
    if (fock_we) begin
      fock_mem[sym2(ca_r, cb_r)] <= sat_res.val;
    end
    coef_rd0_r <= coef_mem[coef_ra0];
    coef_rd1_r <= coef_mem[coef_ra1];
    ham_rd_r   <= ham_mem[ham_ra];
    int_rd0_r  <= int_mem[int_ra0];
    int_rd1_r  <= int_mem[int_ra1];
    den_rd_r   <= den_mem[den_ra];
    den_rdv_r  <= den_vld_r[den_ra];
    fock_rd_r  <= fock_mem[fock_ra];
  end

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_row          = out_row_r;
  assign out_col          = out_col_r;
  assign out_result_value = out_val_r;
  assign out_saturated    = out_sat_r;
  assign out_last         = out_last_r;

  a_last_is_energy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_kind == KIND_ENERGY)
    else $error("last word is not the energy");

  a_lower_triangle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FOCK |-> out_col <= out_row)
    else $error("Fock word above the diagonal");

  a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE ##1 state_r != S_IDLE |-> $past(in_valid && in_cmd == CMD_RUN))
    else $error("sequencer left idle without a run word");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |-> in_stall)
    else $error("output word issued while input open");

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the SCF density, Fock and energy step block.
`default_nettype none
module tb_top;
  import scfd_pkg::*;

  typedef struct {
    logic [1:0]  cmd;
    logic [2:0]  a, b, c, d;
    logic [31:0] value;
  } load_word_t;

  typedef struct {
    logic        kind;
    logic [2:0]  row, col;
    logic [31:0] value;
    logic        clip, last;
  } scf_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [1:0] in_cmd = CMD_LOAD_C;
  logic [2:0] in_index_a = 3'd0, in_index_b = 3'd0, in_index_c = 3'd0, in_index_d = 3'd0;
  logic signed [31:0] in_value = 32'sd0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = REG_BASIS;
  logic [3:0] cfg_data = 4'd0;
  logic in_stall, out_valid, out_kind, out_saturated, out_last, cfg_ready;
  logic [2:0] out_row, out_col;
  logic signed [31:0] out_result_value;

  scf_density_fock_energy_step dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  longint coef_m[64], ham_m[64], eri_m[4096], dens_m[64], fock_m[64];
  bit     coef_wr[64], ham_wr[64], eri_wr[4096];
  int     basis_reg = 8, occ_reg = 1;

  load_word_t pending_q[$];
  scf_word_t  fock_exp_q[$];
  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 0;
  bit  long_hold_req = 0;
  bit  taken = 0;
  int  in_gap = 0, out_gap = 0, hold_cnt = 0;

  function automatic longint floor_shift(longint x, longint y, int sh);
    logic signed [127:0] prod;
    prod = 128'(x) * 128'(y);
    prod = prod >>> sh;
    return longint'(prod);
  endfunction

  function automatic longint clip32(longint x, output bit clip);
    clip = 1'b0;
    if (x > 64'sd2147483647) begin clip = 1'b1; return 64'sd2147483647; end
    if (x < -64'sd2147483648) begin clip = 1'b1; return -64'sd2147483648; end
    return x;
  endfunction

  function automatic int eri_at(int a, int b, int c, int d);
    return ((a * 8 + b) * 8 + c) * 8 + d;
  endfunction

  // Applies one accepted word and queues the results a run produces.
  function automatic void predict_scf(load_word_t w);
    int n, m;
    longint acc, v;
    bit clip;
    scf_word_t res;
    v = longint'(signed'(w.value));
    case (w.cmd)
      CMD_LOAD_C: coef_m[w.a * 8 + w.b] = v;
      CMD_LOAD_H: ham_m[w.a * 8 + w.b] = v;
      CMD_LOAD_I: eri_m[eri_at(w.a, w.b, w.c, w.d)] = v;
      default: begin
        n = (basis_reg > 8) ? 8 : basis_reg;
        m = (occ_reg > 8) ? 8 : occ_reg;
        for (int i = 0; i < n; i++)
          for (int j = 0; j <= i; j++) begin
            acc = dens_m[i * 8 + j];
            for (int k = 0; k < m; k++)
              acc += floor_shift(coef_m[i * 8 + k], coef_m[j * 8 + k], SH_DENS);
            acc = clip32(floor_shift(acc, 1, 1), clip);
            dens_m[i * 8 + j] = acc;
            dens_m[j * 8 + i] = acc;
          end
        for (int r = 0; r < n; r++)
          for (int s = 0; s <= r; s++) begin
            acc = ham_m[r * 8 + s];
            for (int p = 0; p < n; p++)
              for (int q = 0; q < n; q++)
                acc += floor_shift(dens_m[q * 8 + p],
                                   2 * eri_m[eri_at(r, p, s, q)] - eri_m[eri_at(r, p, q, s)],
                                   SH_FOCK);
            acc = clip32(acc, clip);
            fock_m[r * 8 + s] = acc;
            fock_m[s * 8 + r] = acc;
            res = '{KIND_FOCK, 3'(r), 3'(s), 32'(acc), clip, 1'b0};
            fock_exp_q.insert(fock_exp_q.size(), res);
          end
        acc = 0;
        for (int r = 0; r < n; r++)
          for (int s = 0; s < n; s++)
            acc += floor_shift(dens_m[s * 8 + r], ham_m[s * 8 + r] + fock_m[r * 8 + s],
                               SH_FOCK);
        acc = clip32(acc, clip);
        res = '{KIND_ENERGY, 3'd0, 3'd0, 32'(acc), clip, 1'b1};
        fock_exp_q.insert(fock_exp_q.size(), res);
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 262143)) - 131072);
  endfunction

  function automatic void queue_load(logic [1:0] cmd, int a, int b, int c, int d,
                                     logic [31:0] value);
    load_word_t w;
    w = '{cmd, 3'(a), 3'(b), 3'(c), 3'(d), value};
    pending_q.insert(pending_q.size(), w);
    if (cmd == CMD_LOAD_C) coef_wr[a * 8 + b] = 1;
    if (cmd == CMD_LOAD_H) ham_wr[a * 8 + b] = 1;
    if (cmd == CMD_LOAD_I) eri_wr[eri_at(a, b, c, d)] = 1;
  endfunction

  // Loads every entry a run at the given sizes reads that is still unwritten.
  function automatic void fill_unwritten(int nb, int no);
    int n, m;
    n = (nb > 8) ? 8 : nb;
    m = (no > 8) ? 8 : no;
    for (int i = 0; i < n; i++)
      for (int k = 0; k < m; k++)
        if (!coef_wr[i * 8 + k]) queue_load(CMD_LOAD_C, i, k, 0, 0, rand_value());
    for (int r = 0; r < n; r++)
      for (int s = 0; s < n; s++)
        if (!ham_wr[r * 8 + s]) queue_load(CMD_LOAD_H, r, s, 0, 0, rand_value());
    for (int a = 0; a < n; a++)
      for (int b = 0; b < n; b++)
        for (int c = 0; c < n; c++)
          for (int d = 0; d < n; d++)
            if (!eri_wr[eri_at(a, b, c, d)])
              queue_load(CMD_LOAD_I, a, b, c, d, rand_value());
  endfunction

  function automatic void queue_run();
    load_word_t w;
    w = '{CMD_RUN, 3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom), $urandom};
    pending_q.insert(pending_q.size(), w);
  endfunction

  // Accept side of the input channel.
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      predict_scf(pending_q.pop_front());
      taken = 1;
    end
  end

  always @(negedge clk) begin
    if (!(in_valid && !taken)) begin
      taken = 0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        if (!quiet && $urandom_range(0, 3) == 0) begin
          in_gap = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else begin
          in_cmd     <= pending_q[0].cmd;
          in_index_a <= pending_q[0].a;
          in_index_b <= pending_q[0].b;
          in_index_c <= pending_q[0].c;
          in_index_d <= pending_q[0].d;
          in_value   <= pending_q[0].value;
          in_valid   <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, with one long hold while a run is emitting.
  always @(negedge clk) begin
    if (long_hold_req && out_valid) begin
      long_hold_req = 0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      out_gap = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    scf_word_t e;
    if (out_valid && !out_stall) begin
      if (fock_exp_q.size() == 0) begin
        $error("unexpected result word: kind %0d value %0d", out_kind, out_result_value);
        errors++;
      end else begin
        e = fock_exp_q.pop_front();
        if (out_kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_kind); errors++;
        end
        if (out_row !== e.row) begin
          $error("row: expected %0d, got %0d", e.row, out_row); errors++;
        end
        if (out_col !== e.col) begin
          $error("col: expected %0d, got %0d", e.col, out_col); errors++;
        end
        if (out_result_value !== signed'(e.value)) begin
          $error("result_value: expected %0d, got %0d", signed'(e.value), out_result_value);
          errors++;
        end
        if (out_saturated !== e.clip) begin
          $error("saturated: expected %0d, got %0d", e.clip, out_saturated); errors++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_last); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 1000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [3:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BASIS) basis_reg = data;
    if (idx == REG_OCCUPIED) occ_reg = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every word is taken and every result has arrived.
  task automatic drain();
    while (pending_q.size() > 0 || fock_exp_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(int loads);
    int nb;
    nb = $urandom_range(1, 3);
    write_reg(REG_BASIS, 4'(nb));
    write_reg(REG_OCCUPIED, 4'($urandom_range(0, nb + 1)));
    if ($urandom_range(0, 3) == 0) write_reg(2'($urandom_range(2, 3)), 4'($urandom));
    for (int i = 0; i < loads; i++)
      queue_load(2'($urandom_range(0, 2)), $urandom_range(0, 7), $urandom_range(0, 7),
                 $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
    fill_unwritten(basis_reg, occ_reg);
    queue_run();
    if ($urandom_range(0, 1) == 0) queue_run();
    drain();
  endtask

  initial begin
    for (int i = 0; i < 64; i++) dens_m[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // Smallest basis with extreme coefficient and core values.
    write_reg(REG_BASIS, 4'd1);
    write_reg(REG_OCCUPIED, 4'd1);
    queue_load(CMD_LOAD_C, 0, 0, 0, 0, 32'h7fffffff);
    queue_load(CMD_LOAD_H, 0, 0, 0, 0, 32'h80000000);
    queue_load(CMD_LOAD_I, 0, 0, 0, 0, 32'h7fffffff);
    queue_run();
    queue_run();
    drain();
    // No occupied orbitals, then an empty basis that gives only the energy word.
    write_reg(REG_OCCUPIED, 4'd0);
    queue_run();
    drain();
    write_reg(REG_BASIS, 4'd0);
    queue_run();
    drain();
    // Extreme negative values at two functions, with unused register indexes.
    write_reg(REG_BASIS, 4'd2);
    write_reg(REG_OCCUPIED, 4'd2);
    write_reg(2'd2, 4'hf);
    write_reg(2'd3, 4'h5);
    queue_load(CMD_LOAD_C, 1, 1, 7, 7, 32'h80000000);
    queue_load(CMD_LOAD_C, 1, 0, 0, 0, 32'h80000000);
    queue_load(CMD_LOAD_I, 1, 1, 1, 1, 32'h80000000);
    queue_load(CMD_LOAD_H, 7, 7, 7, 7, 32'hffffffff);
    fill_unwritten(2, 2);
    queue_run();
    drain();
    // An oversized orbital count clamps to BASIS_MAX; the receiver holds off here.
    write_reg(REG_BASIS, 4'd3);
    write_reg(REG_OCCUPIED, 4'd15);
    fill_unwritten(3, 15);
    long_hold_req = 1;
    queue_run();
    queue_load(CMD_LOAD_H, 2, 2, 0, 0, rand_value());
    queue_run();
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph >= 9) quiet = 1;
      random_phase(20);
    end
    write_reg(REG_BASIS, 4'd3);
    write_reg(REG_OCCUPIED, 4'd1);
    queue_run();
    drain();

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

>>> scf_density_fock_energy_step.f
src/scfd_pkg.sv
src/scf_density_fock_energy_step.sv
sim/tb_top.sv
